>>> rtl/tcp_retransmit_timer_control_assert.svh
// Assertion macros for the retransmission timer RTL.
`ifndef TCP_RETRANSMIT_TIMER_CONTROL_ASSERT_SVH
`define TCP_RETRANSMIT_TIMER_CONTROL_ASSERT_SVH

`ifndef SYNTH
`define TRTC_ASSERT_IMPLY(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tcp_retransmit_timer_control: same-cycle check failed");
`define TRTC_ASSERT_NEXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tcp_retransmit_timer_control: next-cycle check failed");
`else
`define TRTC_ASSERT_IMPLY(name, clk, rst, cond, prop)
`define TRTC_ASSERT_NEXT(name, clk, rst, cond, prop)
`endif

`endif

>>> rtl/trtc_pkg.sv
// Types, constants and helpers for the TCP retransmission timer control block.
package trtc_pkg;

   localparam int TIME_WIDTH = 20;
   localparam int WIDE_WIDTH = TIME_WIDTH + 4;
   localparam int FLOOR_WIDTH = 16;
   localparam int CAP_WIDTH = 20;
   localparam int LIMIT_WIDTH = 3;
   localparam int COUNT_WIDTH = 3;
   localparam int ACK_WIDTH = 32;
   localparam int CMD_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 20;

   typedef logic [TIME_WIDTH-1:0]  time_type;
   typedef logic [WIDE_WIDTH-1:0]  wide_type;
   typedef logic [FLOOR_WIDTH-1:0] floor_type;
   typedef logic [CAP_WIDTH-1:0]   cap_type;
   typedef logic [LIMIT_WIDTH-1:0] limit_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [ACK_WIDTH-1:0]   ack_type;
   typedef logic [CMD_WIDTH-1:0]   cmd_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam cmd_type CMD_RTT_SAMPLE    = 2'd0;
   localparam cmd_type CMD_TIMEOUT_CHECK = 2'd1;
   localparam cmd_type CMD_ACK_ARRIVAL   = 2'd2;

   localparam csr_index_type CSR_RTO_FLOOR       = 2'd0;
   localparam csr_index_type CSR_RTO_BACKOFF_CAP = 2'd1;
   localparam csr_index_type CSR_DUP_ACK_LIMIT   = 2'd2;

   localparam floor_type RTO_FLOOR_RESET       = 16'd1024;
   localparam cap_type   RTO_BACKOFF_CAP_RESET = 20'd61440;
   localparam limit_type DUP_ACK_LIMIT_RESET   = 3'd3;
   localparam time_type  TIMEOUT_RESET         = time_type'(1024);
   localparam count_type DUP_MAX               = 3'd7;
   localparam time_type  TIME_MAX              = '1;

   typedef struct packed {
      cmd_type         command;
      logic [19:0]     rtt_sample;
      logic [19:0]     elapsed_time;
      ack_type         ack_number;
   } req_type;

   typedef struct packed {
      time_type        timeout_value;
      logic            retransmit_now;
      logic            fast_retransmit;
      count_type       duplicate_count;
   } rsp_type;

   // Step control handed from the top level to each state unit.
   typedef struct packed {
      logic            fire;
      cmd_type         command;
   } step_type;

   typedef struct packed {
      time_type        timeout;
      logic            retransmit;
   } rto_status_type;

   typedef struct packed {
      count_type       count;
      logic            fast;
   } dup_status_type;

   function automatic time_type sat_time(input wide_type value);
      time_type result;
      if (value > wide_type'(TIME_MAX)) begin
         result = TIME_MAX;
      end else begin
         result = value[TIME_WIDTH-1:0];
      end
      return result;
   endfunction

endpackage

>>> rtl/trtc_rto_unit.sv
// Smoothed RTT, RTT variance and retransmission timeout state with its update logic.
module trtc_rto_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  trtc_pkg::step_type      step,
   input  trtc_pkg::time_type      rtt,
   input  trtc_pkg::time_type      elapsed,
   input  trtc_pkg::floor_type     rto_floor,
   input  trtc_pkg::cap_type       backoff_cap,
   output trtc_pkg::rto_status_type status
);

   trtc_pkg::time_type srtt_ff, srtt_in;
   trtc_pkg::time_type rttvar_ff, rttvar_in;
   trtc_pkg::time_type timeout_ff, timeout_in;
   logic               seeded_ff, seeded_in;

   trtc_pkg::time_type diff;
   trtc_pkg::wide_type var_sum;
   trtc_pkg::wide_type srtt_sum;
   trtc_pkg::time_type srtt_upd;
   trtc_pkg::time_type var_upd;
   trtc_pkg::wide_type rto_sum;
   trtc_pkg::wide_type doubled;
   trtc_pkg::wide_type backoff;
   logic               expired;

   always_comb begin
      // Error term uses the smoothed RTT from before this sample.
      if (srtt_ff >= rtt) begin
         diff = srtt_ff - rtt;
      end else begin
         diff = rtt - srtt_ff;
      end
      var_sum  = trtc_pkg::wide_type'(rttvar_ff) + (trtc_pkg::wide_type'(rttvar_ff) << 1)
               + trtc_pkg::wide_type'(diff);
      srtt_sum = (trtc_pkg::wide_type'(srtt_ff) << 3) - trtc_pkg::wide_type'(srtt_ff)
               + trtc_pkg::wide_type'(rtt);
      if (seeded_ff) begin
         var_upd  = trtc_pkg::sat_time(var_sum >> 2);
         srtt_upd = trtc_pkg::sat_time(srtt_sum >> 3);
      end else begin
         var_upd  = rtt >> 1;
         srtt_upd = rtt;
      end
      rto_sum = trtc_pkg::wide_type'(srtt_upd) + (trtc_pkg::wide_type'(var_upd) << 2);
      if (rto_sum < trtc_pkg::wide_type'(rto_floor)) begin
         rto_sum = trtc_pkg::wide_type'(rto_floor);
      end

      expired = elapsed > timeout_ff;
      doubled = trtc_pkg::wide_type'(timeout_ff) << 1;
      if (doubled > trtc_pkg::wide_type'(backoff_cap)) begin
         backoff = trtc_pkg::wide_type'(backoff_cap);
      end else begin
         backoff = doubled;
      end
   end

   always_comb begin
      srtt_in    = srtt_ff;
      rttvar_in  = rttvar_ff;
      timeout_in = timeout_ff;
      seeded_in  = seeded_ff;
      status.retransmit = 1'b0;
      case (step.command)
         trtc_pkg::CMD_RTT_SAMPLE: begin
            srtt_in    = srtt_upd;
            rttvar_in  = var_upd;
            timeout_in = trtc_pkg::sat_time(rto_sum);
            seeded_in  = 1'b1;
         end
         trtc_pkg::CMD_TIMEOUT_CHECK: begin
            if (expired) begin
               timeout_in = trtc_pkg::sat_time(backoff);
               status.retransmit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      status.timeout = timeout_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff    <= '0;
         rttvar_ff  <= '0;
         timeout_ff <= trtc_pkg::TIMEOUT_RESET;
         seeded_ff  <= 1'b0;
      end else if (step.fire) begin
         srtt_ff    <= srtt_in;
         rttvar_ff  <= rttvar_in;
         timeout_ff <= timeout_in;
         seeded_ff  <= seeded_in;
      end
   end

endmodule

>>> rtl/trtc_dup_unit.sv
// Duplicate ACK counter with fast retransmit detection.
module trtc_dup_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  trtc_pkg::step_type       step,
   input  trtc_pkg::ack_type        ack,
   input  trtc_pkg::limit_type      limit,
   output trtc_pkg::dup_status_type status
);

   trtc_pkg::ack_type   prev_ack_ff, prev_ack_in;
   trtc_pkg::count_type count_ff, count_in;
   trtc_pkg::count_type bumped;

   always_comb begin
      prev_ack_in = prev_ack_ff;
      count_in    = count_ff;
      bumped      = count_ff;
      status.fast = 1'b0;
      case (step.command)
         trtc_pkg::CMD_ACK_ARRIVAL: begin
            if (ack == prev_ack_ff) begin
               if (count_ff < trtc_pkg::DUP_MAX) begin
                  bumped = count_ff + trtc_pkg::count_type'(1);
               end
            end else begin
               prev_ack_in = ack;
               bumped      = '0;
            end
            // Reaching the limit fires once and starts the count over.
            if (bumped >= limit) begin
               status.fast = 1'b1;
               count_in    = '0;
            end else begin
               count_in    = bumped;
            end
         end
         default: begin
         end
      endcase
      status.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ack_ff <= '0;
         count_ff    <= '0;
      end else if (step.fire) begin
         prev_ack_ff <= prev_ack_in;
         count_ff    <= count_in;
      end
   end

endmodule

>>> rtl/tcp_retransmit_timer_control.sv
// Top level of the TCP retransmission timer control block.
// Sender-side retransmission control for one TCP connection. Each request
// transaction carries one event: an RTT sample (updates smoothed RTT and
// variance and recomputes the timeout), a timeout check (flags a retransmit
// and doubles the timeout up to rto_backoff_cap when the oldest segment's
// age exceeds it) or a pure ACK (counts duplicates and flags fast retransmit
// at dup_ack_limit). Times are unsigned in 1/1024 second units. Every event
// gives exactly one response transaction. The block takes one transaction
// per cycle unless the response side stalls; an accepted request loads the
// input register, and the update logic's result then loads the response
// register, where it is valid. State updates are registered as each event
// fires, so consecutive events see each other's results with no bubbles.
// The register file must be written through the csr_ port only while no
// transaction is in flight; the block itself does not enforce this.
`include "tcp_retransmit_timer_control_assert.svh"

module tcp_retransmit_timer_control (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  trtc_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output trtc_pkg::rsp_type          rsp_payload,
   input  logic                       csr_write_enable,
   input  trtc_pkg::csr_index_type    csr_index,
   input  trtc_pkg::csr_data_type     csr_wdata
);

   logic                   in_valid_ff, in_valid_in;
   trtc_pkg::req_type      in_data_ff;
   logic                   out_valid_ff, out_valid_in;
   trtc_pkg::rsp_type      out_data_ff, out_data_in;
   trtc_pkg::floor_type    floor_ff;
   trtc_pkg::cap_type      cap_ff;
   trtc_pkg::limit_type    limit_ff;

   logic                   advance;
   trtc_pkg::step_type     step;
   trtc_pkg::time_type     rtt;
   trtc_pkg::time_type     elapsed;
   trtc_pkg::rto_status_type rto_status;
   trtc_pkg::dup_status_type dup_status;

   // The response register can load whenever it is empty or being drained.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   assign step.fire    = in_valid_ff && advance;
   assign step.command = in_data_ff.command;
   assign rtt     = trtc_pkg::time_type'(in_data_ff.rtt_sample);
   assign elapsed = trtc_pkg::time_type'(in_data_ff.elapsed_time);

   trtc_rto_unit u_rto (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rtt         (rtt),
      .elapsed     (elapsed),
      .rto_floor   (floor_ff),
      .backoff_cap (cap_ff),
      .status      (rto_status)
   );

   trtc_dup_unit u_dup (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .ack    (in_data_ff.ack_number),
      .limit  (limit_ff),
      .status (dup_status)
   );

   always_comb begin
      out_data_in.timeout_value   = rto_status.timeout;
      out_data_in.retransmit_now  = rto_status.retransmit;
      out_data_in.fast_retransmit = dup_status.fast;
      out_data_in.duplicate_count = dup_status.count;
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (step.fire) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= trtc_pkg::RTO_FLOOR_RESET;
         cap_ff   <= trtc_pkg::RTO_BACKOFF_CAP_RESET;
         limit_ff <= trtc_pkg::DUP_ACK_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            trtc_pkg::CSR_RTO_FLOOR: begin
               floor_ff <= csr_wdata[trtc_pkg::FLOOR_WIDTH-1:0];
            end
            trtc_pkg::CSR_RTO_BACKOFF_CAP: begin
               cap_ff <= csr_wdata[trtc_pkg::CAP_WIDTH-1:0];
            end
            trtc_pkg::CSR_DUP_ACK_LIMIT: begin
               limit_ff <= csr_wdata[trtc_pkg::LIMIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   `TRTC_ASSERT_NEXT(a_accept_loads_input, clock, reset, req_valid && req_ready, in_valid_ff)
   `TRTC_ASSERT_NEXT(a_step_loads_response, clock, reset, step.fire, out_valid_ff)
   `TRTC_ASSERT_IMPLY(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_payload.retransmit_now && rsp_payload.fast_retransmit))
   `TRTC_ASSERT_IMPLY(a_fast_clears_count, clock, reset, rsp_valid && rsp_payload.fast_retransmit, rsp_payload.duplicate_count == '0)
   `TRTC_ASSERT_IMPLY(a_backoff_within_cap, clock, reset, rsp_valid && rsp_payload.retransmit_now, rsp_payload.timeout_value <= cap_ff)

endmodule
